@@ design/round_robin_multi_queue_dispatcher_assert.svh @@
// Assertion macros used by the checker file of the dispatcher.
`ifndef ROUND_ROBIN_MULTI_QUEUE_DISPATCHER_ASSERT_SVH
`define ROUND_ROBIN_MULTI_QUEUE_DISPATCHER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define RRMQD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define RRMQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RRMQD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rrmqd_pkg.sv @@
package rrmqd_pkg;

  // Field widths of the channels
  localparam int WIDX_W     = 3;
  localparam int HANDLE_W   = 16;
  localparam int ARG_W      = 32;
  localparam int WIU_W      = 4;
  localparam int SPW_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 2'd1;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_PUSH
  } state_t;

endpackage

@@ design/rrmqd_rr_ptr.sv @@
module rrmqd_rr_ptr #(
  parameter int MAX_WORKERS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rrmqd_pkg::WIU_W-1:0]     workers_in_use,
  input  logic                            reload,
  input  logic                            advance,
  output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] worker,
  output logic                            busy
);

  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW = $clog2(MAX_WORKERS + 1);

  logic [NW-1:0] count;
  logic [WW-1:0] ptr;
  logic [WW-1:0] raw;
  logic [WW-1:0] ptr_step;
  logic          renorm;

  // Saturate the worker count into 1..MAX_WORKERS
  always_comb begin
    if (workers_in_use == '0) begin
      count = NW'(1);
    end else if (32'(workers_in_use) > 32'(MAX_WORKERS)) begin
      count = NW'(MAX_WORKERS);
    end else begin
      count = NW'(workers_in_use);
    end
  end

  // Worker that follows the current one under the current count
  assign ptr_step = (32'(ptr) + 32'd1 >= 32'(count)) ? '0 : ptr + WW'(1);

  // Keep the pointer as last advanced in raw; after a count change, fold a
  // copy of it back below the count by one subtraction per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      raw    <= '0;
      renorm <= 1'b0;
    end else if (reload) begin
      renorm <= 1'b1;
      if (advance) begin
        ptr <= ptr_step;
        raw <= ptr_step;
      end else begin
        ptr <= raw;
      end
    end else if (renorm) begin
      if (32'(ptr) >= 32'(count)) begin
        ptr <= ptr - WW'(count);
      end else begin
        renorm <= 1'b0;
      end
    end else if (advance) begin
      ptr <= ptr_step;
      raw <= ptr_step;
    end
  end

  assign worker = ptr;
  assign busy   = renorm;

endmodule

@@ design/round_robin_multi_queue_dispatcher.sv @@
// Channel  Handshake              Word
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
// in       in_valid / in_ready    op, worker_index, task_handle, task_arg
// out      out_valid / out_ready  status, target_worker, out_handle, out_arg, wake
//
// One word passes three steps: accept (queue metadata read), update (metadata and
// task memory access), result load; the next word is accepted once back in idle.
// The metadata memory read-modify-write sets these steps; one word is in work at a time.
// A finished result waits in the output register while the next word is accepted.
// Reset clears control state and queue metadata valid bits; in_ready is high
// on the first cycle after reset. A workers_in_use write holds in_ready low
// while the round-robin pointer is folded into range.
module round_robin_multi_queue_dispatcher #(
  parameter int MAX_WORKERS = 8,
  parameter int MAX_SLOTS   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rrmqd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrmqd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [rrmqd_pkg::WIDX_W-1:0]         worker_index,
  input  logic [rrmqd_pkg::HANDLE_W-1:0]       task_handle,
  input  logic [rrmqd_pkg::ARG_W-1:0]          task_arg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [rrmqd_pkg::WIDX_W-1:0]         target_worker,
  output logic [rrmqd_pkg::HANDLE_W-1:0]       out_handle,
  output logic [rrmqd_pkg::ARG_W-1:0]          out_arg,
  output logic                                 wake
);

  localparam int WW     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OCW    = $clog2(MAX_SLOTS + 1);
  localparam int AW     = WW + SW;
  localparam int WDEPTH = 2 ** WW;
  localparam int SDEPTH = 2 ** AW;
  localparam int TW     = rrmqd_pkg::HANDLE_W + rrmqd_pkg::ARG_W;
  localparam logic [rrmqd_pkg::WIU_W-1:0] WIU_RST =
    (MAX_WORKERS < 8) ? rrmqd_pkg::WIU_W'(MAX_WORKERS) : rrmqd_pkg::WIU_W'(8);
  localparam logic [rrmqd_pkg::SPW_W-1:0] SPW_RST =
    (MAX_SLOTS < 64) ? rrmqd_pkg::SPW_W'(MAX_SLOTS) : rrmqd_pkg::SPW_W'(64);

  typedef struct packed {
    logic [OCW-1:0] occ;
    logic [SW-1:0]  wr;
    logic [SW-1:0]  rd;
  } meta_t;

  rrmqd_pkg::state_t  state, state_next;
  rrmqd_pkg::status_t st_c, res_st;

  logic [rrmqd_pkg::WIU_W-1:0]    wiu;
  logic [rrmqd_pkg::SPW_W-1:0]    spw;
  logic [OCW-1:0]                 cap;
  logic                           in_acc, out_free, push_load, meta_stage;
  logic                           rr_busy, rr_reload, rr_advance;
  logic [WW-1:0]                  rr_worker, wk_sel, wk_q;
  logic                           op_q, bad_q;
  logic [rrmqd_pkg::WIDX_W-1:0]   tgt_q;
  logic [rrmqd_pkg::HANDLE_W-1:0] h_q;
  logic [rrmqd_pkg::ARG_W-1:0]    a_q;

  meta_t                          meta_mem [WDEPTH];
  logic [WDEPTH-1:0]              meta_vld;
  meta_t                          meta_q, meta_new;
  logic                           meta_vld_q;
  logic [OCW-1:0]                 occ;
  logic [SW-1:0]                  wr, rd;
  logic                           full, empty, meta_we, store_we, store_re, wake_c;

  logic [TW-1:0]                  task_store [SDEPTH];
  logic [TW-1:0]                  store_q;
  logic                           res_wake, res_deq;

  function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] p,
                                              input logic [OCW-1:0] c);
    ring_next = (32'(p) + 32'd1 >= 32'(c)) ? '0 : p + SW'(1);
  endfunction

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wiu <= WIU_RST;
      spw <= SPW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rrmqd_pkg::CFG_WORKERS: wiu <= cfg_data[rrmqd_pkg::WIU_W-1:0];
        rrmqd_pkg::CFG_SLOTS:   spw <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the ring capacity into 1..MAX_SLOTS
  always_comb begin
    if (spw == '0) begin
      cap = OCW'(1);
    end else if (32'(spw) > 32'(MAX_SLOTS)) begin
      cap = OCW'(MAX_SLOTS);
    end else begin
      cap = OCW'(spw);
    end
  end

  // Round-robin worker pointer
  assign rr_reload  = cfg_valid && cfg_ready && (cfg_index == rrmqd_pkg::CFG_WORKERS);
  assign rr_advance = in_acc && (op == rrmqd_pkg::OP_ENQ);

  rrmqd_rr_ptr #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_rr_ptr (
    .clk            (clk),
    .rst            (rst),
    .workers_in_use (wiu),
    .reload         (rr_reload),
    .advance        (rr_advance),
    .worker         (rr_worker),
    .busy           (rr_busy)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrmqd_pkg::S_IDLE: if (in_acc) state_next = rrmqd_pkg::S_META;
      rrmqd_pkg::S_META: state_next = rrmqd_pkg::S_PUSH;
      rrmqd_pkg::S_PUSH: if (out_free) state_next = rrmqd_pkg::S_IDLE;
      default:           state_next = rrmqd_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready   = (state == rrmqd_pkg::S_IDLE) && !rr_busy;
    meta_stage = (state == rrmqd_pkg::S_META);
    out_free   = !out_valid || out_ready;
    push_load  = (state == rrmqd_pkg::S_PUSH) && out_free;
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrmqd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the word and pick the queue it touches
  assign wk_sel = (op == rrmqd_pkg::OP_DEQ) ? WW'(worker_index) : rr_worker;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q  <= op;
      wk_q  <= wk_sel;
      tgt_q <= (op == rrmqd_pkg::OP_DEQ) ? worker_index : rrmqd_pkg::WIDX_W'(rr_worker);
      bad_q <= (op == rrmqd_pkg::OP_DEQ) && (32'(worker_index) >= 32'(MAX_WORKERS));
      h_q   <= task_handle;
      a_q   <= task_arg;
    end
  end

  // Queue metadata memory: read on accept, write back in the update cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta_q <= meta_mem[wk_sel];
    end
    if (meta_we) begin
      meta_mem[wk_q] <= meta_new;
    end
  end

  // Valid bits: an entry never written reads as an empty queue
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld <= '0;
    end else if (meta_we) begin
      meta_vld[wk_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta_vld_q <= meta_vld[wk_sel];
    end
  end

  // Update: decide the outcome and the new ring state
  always_comb begin
    occ      = meta_vld_q ? meta_q.occ : '0;
    wr       = meta_vld_q ? meta_q.wr : '0;
    rd       = meta_vld_q ? meta_q.rd : '0;
    full     = (occ >= cap);
    empty    = bad_q || (occ == '0);
    meta_new.occ = occ;
    meta_new.wr  = wr;
    meta_new.rd  = rd;
    meta_we  = 1'b0;
    store_we = 1'b0;
    store_re = 1'b0;
    wake_c   = 1'b0;
    st_c     = rrmqd_pkg::ST_EMPTY;
    if (op_q == rrmqd_pkg::OP_ENQ) begin
      if (full) begin
        st_c   = rrmqd_pkg::ST_DROP;
        wake_c = (occ == OCW'(1));
      end else begin
        st_c         = rrmqd_pkg::ST_ENQ;
        wake_c       = (occ == '0);
        meta_we      = meta_stage;
        store_we     = meta_stage;
        meta_new.occ = occ + OCW'(1);
        meta_new.wr  = ring_next(wr, cap);
      end
    end else if (!empty) begin
      st_c         = rrmqd_pkg::ST_DEQ;
      meta_we      = meta_stage;
      store_re     = meta_stage;
      meta_new.occ = occ - OCW'(1);
      meta_new.rd  = ring_next(rd, cap);
    end
  end

  // Task memory: append on enqueue, fetch oldest on dequeue
  always_ff @(posedge clk) begin
    if (store_we) begin
      task_store[{wk_q, wr}] <= {h_q, a_q};
    end
    if (store_re) begin
      store_q <= task_store[{wk_q, rd}];
    end
  end

  // Hold the outcome until the output register frees up
  always_ff @(posedge clk) begin
    if (meta_stage) begin
      res_st   <= st_c;
      res_wake <= wake_c;
      res_deq  <= store_re;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_load) begin
      status        <= res_st;
      target_worker <= tgt_q;
      out_handle    <= res_deq ? store_q[TW-1:rrmqd_pkg::ARG_W] : '0;
      out_arg       <= res_deq ? store_q[rrmqd_pkg::ARG_W-1:0] : '0;
      wake          <= res_wake;
    end
  end

endmodule

@@ design/rrmqd_checker.sv @@
`include "round_robin_multi_queue_dispatcher_assert.svh"

module rrmqd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         status,
  input logic [rrmqd_pkg::WIDX_W-1:0]       target_worker,
  input logic [rrmqd_pkg::HANDLE_W-1:0]     out_handle,
  input logic [rrmqd_pkg::ARG_W-1:0]        out_arg,
  input logic                               wake
);

  logic [1:0] pending;

  // Count words accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'((in_valid && in_ready) ? 1 : 0)
                         - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  `RRMQD_ASSERT_RST(a_reset_clears_out, rst, !out_valid, "result valid right after reset")

  `RRMQD_ASSERT(a_no_orphan_word, out_valid, pending != 2'd0, "result with no word accepted")

  `RRMQD_ASSERT(a_one_in_work, in_valid && in_ready, pending <= 2'd1, "too many words in flight")

  `RRMQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(target_worker) && $stable(out_handle) && $stable(out_arg) && $stable(wake), "stalled result changed")

  `RRMQD_ASSERT(a_fields_zero, out_valid && status != rrmqd_pkg::ST_DEQ, out_handle == '0 && out_arg == '0 && (!wake || status == rrmqd_pkg::ST_ENQ || status == rrmqd_pkg::ST_DROP), "non-dequeue result carries task data or wake")

endmodule

bind round_robin_multi_queue_dispatcher rrmqd_checker u_rrmqd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .target_worker (target_worker),
  .out_handle    (out_handle),
  .out_arg       (out_arg),
  .wake          (wake)
);

@@ tb/tb_round_robin_multi_queue_dispatcher.sv @@
module tb_round_robin_multi_queue_dispatcher;
  import rrmqd_pkg::*;

  localparam int NUM_WORKERS = 8;
  localparam int NUM_SLOTS   = 64;
  localparam int PHASE_WORDS = 155;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  // One request word and one reply word
  typedef struct {
    op_t                 op;
    logic [WIDX_W-1:0]   widx;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
  } request_t;

  typedef struct {
    status_t             status;
    logic [WIDX_W-1:0]   worker;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
    logic                wake;
  } reply_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_WORKERS;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic                  op            = 1'b0;
  logic [WIDX_W-1:0]     worker_index  = '0;
  logic [HANDLE_W-1:0]   task_handle   = '0;
  logic [ARG_W-1:0]      task_arg      = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [1:0]            status;
  logic [WIDX_W-1:0]     target_worker;
  logic [HANDLE_W-1:0]   out_handle;
  logic [ARG_W-1:0]      out_arg;
  logic                  wake;

  round_robin_multi_queue_dispatcher #(
    .MAX_WORKERS(NUM_WORKERS),
    .MAX_SLOTS  (NUM_SLOTS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .worker_index (worker_index),
    .task_handle  (task_handle),
    .task_arg     (task_arg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .target_worker(target_worker),
    .out_handle   (out_handle),
    .out_arg      (out_arg),
    .wake         (wake)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the dispatcher: registers, round-robin pointer and worker rings
  logic [WIU_W-1:0]          wiu_shadow;
  logic [SPW_W-1:0]          spw_shadow;
  int unsigned               rr_next;
  int unsigned               ring_wr    [NUM_WORKERS];
  int unsigned               ring_rd    [NUM_WORKERS];
  int unsigned               ring_count [NUM_WORKERS];
  logic [HANDLE_W+ARG_W-1:0] ring_mem   [NUM_WORKERS*NUM_SLOTS];

  request_t    pending_requests [$];
  reply_t      expected_replies [$];
  request_t    in_flight;
  reply_t      want;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req   = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned words_accepted = 0;
  int unsigned replies_seen   = 0;
  int unsigned settings_run   = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};
  int unsigned cycles = 0;
  int unsigned errors = 0;

  function automatic int unsigned workers_active();
    if (wiu_shadow == 0) return 1;
    if (wiu_shadow > NUM_WORKERS) return NUM_WORKERS;
    return wiu_shadow;
  endfunction

  // Compute the reply of one request word and advance the shadow state
  function automatic reply_t dispatch_predict(request_t rq);
    reply_t      rp;
    int unsigned n, cap, w, s;
    n   = workers_active();
    cap = (spw_shadow == 0) ? 1 : (spw_shadow > NUM_SLOTS) ? NUM_SLOTS : spw_shadow;
    rp.status = ST_EMPTY;
    rp.handle = '0;
    rp.arg    = '0;
    rp.wake   = 1'b0;
    if (rq.op == OP_ENQ) begin
      // pick the worker, advance the pointer even on a drop
      w = rr_next % n;
      rr_next = (w + 1) % n;
      rp.worker = WIDX_W'(w);
      if (ring_count[w] >= cap) begin
        rp.status = ST_DROP;
      end else begin
        s = ring_wr[w] % NUM_SLOTS;
        ring_mem[w*NUM_SLOTS+s] = {rq.handle, rq.arg};
        ring_count[w]++;
        ring_wr[w] = (s + 1 >= cap) ? 0 : s + 1;
        rp.status = ST_ENQ;
      end
      rp.wake = (ring_count[w] == 1);
    end else begin
      // serve the named worker, in use or not
      w = rq.widx;
      rp.worker = rq.widx;
      if (ring_count[w] != 0) begin
        s = ring_rd[w] % NUM_SLOTS;
        {rp.handle, rp.arg} = ring_mem[w*NUM_SLOTS+s];
        ring_rd[w] = (s + 1 >= cap) ? 0 : s + 1;
        ring_count[w]--;
        rp.status = ST_DEQ;
      end
    end
    return rp;
  endfunction

  function automatic void field_check(string name, logic [31:0] exp_val, logic [31:0] got);
    if (exp_val !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, got);
      errors++;
    end
  endfunction

  function automatic void queue_request(op_t o, logic [WIDX_W-1:0] w, logic [HANDLE_W-1:0] h,
                                        logic [ARG_W-1:0] a);
    request_t rq;
    rq.op     = o;
    rq.widx   = w;
    rq.handle = h;
    rq.arg    = a;
    pending_requests.push_back(rq);
  endfunction

  // Random word; dequeues mostly aim at workers in use
  function automatic request_t random_request(int unsigned enq_pct);
    request_t rq;
    rq.op     = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
    rq.widx   = ($urandom_range(3) != 0) ? WIDX_W'($urandom_range(workers_active() - 1))
                                         : WIDX_W'($urandom);
    rq.handle = HANDLE_W'($urandom);
    rq.arg    = $urandom;
    if ($urandom_range(7) == 0) rq.handle = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(7) == 0) rq.arg = $urandom_range(1) ? '1 : '0;
    return rq;
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WORKERS) wiu_shadow = val[WIU_W-1:0];
    else if (idx == CFG_SLOTS) spw_shadow = val;
  endtask

  // New register setting, then bursts that alternate between filling and draining
  task automatic run_setting(logic [CFG_DATA_W-1:0] wiu_val, logic [CFG_DATA_W-1:0] spw_val,
                             int unsigned send_pct, int unsigned recv_pct);
    int unsigned enq_pct;
    int unsigned burst;
    wait_idle();
    write_reg(CFG_WORKERS, wiu_val);
    write_reg(CFG_SLOTS, spw_val);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    enq_pct = 25;
    burst   = 0;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (burst == 0) begin
        enq_pct = (enq_pct == 80) ? 25 : 80;
        burst   = $urandom_range(40, 8);
      end
      burst--;
      pending_requests.push_back(random_request(enq_pct));
    end
    settings_run++;
  endtask

  // Drive request words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // record the word taken at this edge
      if (in_valid && in_ready) begin
        expected_replies.push_back(dispatch_predict(in_flight));
        words_accepted++;
      end
      // offer the next word unless one is still held
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_requests.pop_front();
          in_valid     <= 1'b1;
          op           <= in_flight.op;
          worker_index <= in_flight.widx;
          task_handle  <= in_flight.handle;
          task_arg     <= in_flight.arg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check reply words and drive out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply: status %0d worker %0d", $time, status, target_worker);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          field_check("status", want.status, status);
          field_check("target_worker", want.worker, target_worker);
          field_check("out_handle", want.handle, out_handle);
          field_check("out_arg", want.arg, out_arg);
          field_check("wake", want.wake, wake);
        end
        replies_seen++;
        if (!$isunknown(status)) status_hits[status]++;
      end
      // hold off for a long stretch on request, else stall at random
      if (hold_taken != hold_req) begin
        hold_taken <= hold_req;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycles,
               expected_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    wiu_shadow = 4'd8;
    spw_shadow = 7'd64;
    rr_next    = 0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      ring_wr[w]    = 0;
      ring_rd[w]    = 0;
      ring_count[w] = 0;
    end
    for (int i = 0; i < NUM_WORKERS * NUM_SLOTS; i++) ring_mem[i] = '0;
    send_idle_pct = 21;
    recv_idle_pct = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queues, extreme contents, wake, order of a worker's ring
    queue_request(OP_DEQ, 3'd0, '0, '0);
    queue_request(OP_DEQ, 3'd7, '1, '1);
    queue_request(OP_ENQ, 3'd0, '0, '0);
    queue_request(OP_ENQ, 3'd7, '1, '1);
    queue_request(OP_ENQ, 3'd0, 16'hA5A5, 32'h5A5A_5A5A);
    queue_request(OP_ENQ, 3'd5, 16'h5A5A, 32'hA5A5_A5A5);
    queue_request(OP_ENQ, 3'd0, 16'h8001, 32'h8000_0001);
    queue_request(OP_ENQ, 3'd0, 16'h0F0F, 32'hF0F0_F0F0);
    queue_request(OP_ENQ, 3'd0, 16'h3C3C, 32'hC3C3_C3C3);
    queue_request(OP_ENQ, 3'd0, 16'h7FFE, 32'h7FFF_FFFE);
    queue_request(OP_ENQ, 3'd0, 16'h0001, 32'h0000_0001);
    queue_request(OP_DEQ, 3'd0, '0, '0);
    queue_request(OP_DEQ, 3'd0, '0, '0);
    queue_request(OP_DEQ, 3'd0, '0, '0);
    queue_request(OP_DEQ, 3'd1, '0, '0);
    queue_request(OP_DEQ, 3'd7, '0, '0);
    queue_request(OP_DEQ, 3'd7, '0, '0);
    queue_request(OP_ENQ, 3'd0, 16'hFFFF, 32'h0000_0000);

    // Drain, then write every slot of every ring and overflow each once
    wait_idle();
    for (int w = 0; w < NUM_WORKERS; w++)
      repeat (ring_count[w]) queue_request(OP_DEQ, WIDX_W'(w), '0, '0);
    wait_idle();
    hold_req <= hold_req + 1;
    repeat (NUM_WORKERS * NUM_SLOTS + NUM_WORKERS)
      pending_requests.push_back(random_request(100));

    // Register settings, extremes and out-of-range values among them
    run_setting(7'd1, 7'd1, 21, 66);
    run_setting(7'd3, 7'd5, 21, 66);
    run_setting(7'd8, 7'd2, 66, 21);
    run_setting(7'd0, 7'd0, 66, 21);
    hold_req <= hold_req + 1;
    run_setting(7'd15, 7'd127, 66, 21);
    run_setting(7'h13, 7'd64, 66, 21);
    run_setting(7'd9, 7'd65, 0, 0);
    run_setting(7'd2, 7'd3, 0, 0);
    run_setting(7'd8, 7'd64, 0, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d request words under %0d register settings, %0d replies checked",
             words_accepted, settings_run, replies_seen);
    $display("Replies seen: %0d enqueued, %0d dropped, %0d dequeued, %0d empty",
             status_hits[ST_ENQ], status_hits[ST_DROP], status_hits[ST_DEQ],
             status_hits[ST_EMPTY]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
